// ===== src/usart_register_block_core_assert.svh =====
// Assertion macros for the register block core.
`ifndef USART_REGISTER_BLOCK_CORE_ASSERT_SVH
`define USART_REGISTER_BLOCK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define USART_RB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("usart register block: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define USART_RB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("usart register block: next-cycle check failed");

`endif

// ===== src/usart_rb_pkg.sv =====
// Package with the register map, command codes and shared types of the USART block.
`default_nettype none

package usart_rb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_RX    = 2'd3
    } t_cmd;

    localparam logic [2:0] REG_STATUS  = 3'd0;
    localparam logic [2:0] REG_DATA    = 3'd1;
    localparam logic [2:0] REG_DIVISOR = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;

    // Status register bits.
    localparam int unsigned SR_RXNE = 5;
    localparam int unsigned SR_TC   = 6;
    localparam int unsigned SR_TXE  = 7;

    // Control register bits.
    localparam int unsigned CR_UE     = 13;
    localparam int unsigned CR_TXEIE  = 7;
    localparam int unsigned CR_RXNEIE = 5;
    localparam int unsigned CR_TE     = 3;
    localparam int unsigned CR_RE     = 2;

    localparam int unsigned CTRL_W = 14;

    localparam logic [15:0] DIVISOR_RESET = 16'd16;
    localparam logic [3:0]  FRAME_BITS    = 4'd10;

    typedef struct packed {
        logic frame_end;
        logic load;
    } t_tx_event;

endpackage

`default_nettype wire

// ===== src/usart_rb_tx.sv =====
// 8N1 transmit shifter with its bit timer, advanced once per accepted request.
`default_nettype none

module usart_rb_tx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [15:0]           i_divisor,
    input  logic                  i_enable,
    input  logic                  i_tx_empty,
    input  logic [7:0]            i_tx_hold,
    output usart_rb_pkg::t_tx_event o_event,
    output logic                  o_tx_line
);
    import usart_rb_pkg::*;

    logic [9:0]  r_shifter;
    logic [9:0]  n_shifter;
    logic [3:0]  r_bits_left;
    logic [3:0]  n_bits_left;
    logic [15:0] r_bit_timer;
    logic [15:0] n_bit_timer;
    logic [15:0] div_eff;

    always_comb begin
        div_eff     = (i_divisor == 16'd0) ? 16'd1 : i_divisor;
        n_shifter   = r_shifter;
        n_bits_left = r_bits_left;
        n_bit_timer = r_bit_timer;
        o_event     = '0;
        if (r_bits_left != 4'd0) begin
            n_bit_timer = r_bit_timer + 16'd1;
            if (n_bit_timer >= div_eff) begin
                n_bit_timer       = 16'd0;
                n_shifter         = {1'b1, r_shifter[9:1]};
                n_bits_left       = r_bits_left - 4'd1;
                o_event.frame_end = (n_bits_left == 4'd0);
            end
        end
        // A new frame starts in the same tick in which the previous one ends.
        if (n_bits_left == 4'd0 && !i_tx_empty && i_enable) begin
            n_shifter    = {1'b1, i_tx_hold, 1'b0};
            n_bits_left  = FRAME_BITS;
            n_bit_timer  = 16'd0;
            o_event.load = 1'b1;
        end
        o_tx_line = n_shifter[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifter   <= '1;
            r_bits_left <= '0;
            r_bit_timer <= '0;
        end else if (i_advance) begin
            r_shifter   <= n_shifter;
            r_bits_left <= n_bits_left;
            r_bit_timer <= n_bit_timer;
        end
    end

endmodule

`default_nettype wire

// ===== src/usart_register_block_core.sv =====
// Top level of the USART register block: request register, register file and result register.
// Usage:
//   Each request on the input channel (i_valid/o_ready) is one peripheral clock tick,
//   carrying an optional bus read, bus write or received byte (i_cmd selects which).
//   Each request yields exactly one result on the output channel (o_valid/i_ready):
//   the read data (zero unless a read), the transmit line level and the interrupt
//   request, all as they stand after that tick.
//   A request passes the request register, then the result register.
//   Throughput is one request per cycle while the receiver takes results; the whole tick
//   is a single combinational pass from the request register through the register file
//   and the transmit shifter into the result register.
//   When the receiver stalls, the pending result holds, the request register keeps
//   its request and at most one further request is taken before o_ready falls.
//   User writes the baud divisor (i_cfg_wr_en/i_cfg_wr_data) only while idle; not enforced.
//   Reset clears both pipeline registers, sets the divisor to 16, clears the control
//   and receive registers, sets TXE and TC, and sets the transmit shifter idle high.
`default_nettype none

`include "usart_register_block_core_assert.svh"

module usart_register_block_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_reg_index,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_read_data,
    output logic        o_tx_line,
    output logic        o_interrupt
);
    import usart_rb_pkg::*;

    // Request register.
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [2:0]  r_in_reg_index;
    logic [15:0] r_in_write_data;
    logic [7:0]  r_in_rx_byte;

    // Register file.
    logic [15:0]       r_divisor;
    logic [CTRL_W-1:0] r_ctrl;
    logic [CTRL_W-1:0] n_ctrl;
    logic [7:0]        r_rx_data;
    logic [7:0]        n_rx_data;
    logic              r_rx_full;
    logic              n_rx_full;
    logic [7:0]        r_tx_hold;
    logic [7:0]        n_tx_hold;
    logic              r_tx_empty;
    logic              n_tx_empty;
    logic              r_tx_complete;
    logic              n_tx_complete;

    // Result register.
    logic        r_out_valid;
    logic [15:0] r_out_read_data;
    logic        r_out_tx_line;
    logic        r_out_irq;

    logic        advance;
    t_cmd        cmd;
    logic [15:0] rd_data;
    logic        mid_tx_empty;
    logic        mid_tx_complete;
    logic        tx_line;
    logic        irq;
    t_tx_event   tx_event;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd        <= i_cmd;
            r_in_reg_index  <= i_reg_index;
            r_in_write_data <= i_write_data;
            r_in_rx_byte    <= i_rx_byte;
        end
    end

    // Bus or receive action; a read sees the registers from before this tick.
    always_comb begin
        cmd             = t_cmd'(r_in_cmd);
        rd_data         = '0;
        n_ctrl          = r_ctrl;
        n_rx_data       = r_rx_data;
        n_rx_full       = r_rx_full;
        n_tx_hold       = r_tx_hold;
        mid_tx_empty    = r_tx_empty;
        mid_tx_complete = r_tx_complete;
        unique case (cmd)
            CMD_READ: begin
                unique case (r_in_reg_index)
                    REG_STATUS: begin
                        rd_data[SR_RXNE] = r_rx_full;
                        rd_data[SR_TC]   = r_tx_complete;
                        rd_data[SR_TXE]  = r_tx_empty;
                    end
                    REG_DATA: begin
                        rd_data   = {8'd0, r_rx_data};
                        n_rx_full = 1'b0;
                    end
                    REG_DIVISOR: rd_data = r_divisor;
                    REG_CONTROL: rd_data = {{(16 - CTRL_W){1'b0}}, r_ctrl};
                    default:     rd_data = '0;
                endcase
            end
            CMD_WRITE: begin
                if (r_in_reg_index == REG_DATA) begin
                    n_tx_hold       = r_in_write_data[7:0];
                    mid_tx_empty    = 1'b0;
                    mid_tx_complete = 1'b0;
                end else if (r_in_reg_index == REG_CONTROL) begin
                    n_ctrl = r_in_write_data[CTRL_W-1:0];
                end
            end
            CMD_RX: begin
                // A byte arriving while the receiver is disabled is dropped.
                if (r_ctrl[CR_UE] && r_ctrl[CR_RE]) begin
                    n_rx_data = r_in_rx_byte;
                    n_rx_full = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    usart_rb_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_divisor  (r_divisor),
        .i_enable   (n_ctrl[CR_UE] & n_ctrl[CR_TE]),
        .i_tx_empty (mid_tx_empty),
        .i_tx_hold  (n_tx_hold),
        .o_event    (tx_event),
        .o_tx_line  (tx_line)
    );

    always_comb begin
        n_tx_empty    = mid_tx_empty | tx_event.load;
        n_tx_complete = mid_tx_complete | (tx_event.frame_end & mid_tx_empty);
        irq           = n_ctrl[CR_UE] & ((n_ctrl[CR_TXEIE] & n_tx_empty) |
                                         (n_ctrl[CR_RXNEIE] & n_rx_full));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIVISOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_divisor <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl        <= '0;
            r_rx_data     <= '0;
            r_rx_full     <= 1'b0;
            r_tx_hold     <= '0;
            r_tx_empty    <= 1'b1;
            r_tx_complete <= 1'b1;
        end else if (advance) begin
            r_ctrl        <= n_ctrl;
            r_rx_data     <= n_rx_data;
            r_rx_full     <= n_rx_full;
            r_tx_hold     <= n_tx_hold;
            r_tx_empty    <= n_tx_empty;
            r_tx_complete <= n_tx_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_read_data <= rd_data;
            r_out_tx_line   <= tx_line;
            r_out_irq       <= irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_read_data;
    assign o_tx_line   = r_out_tx_line;
    assign o_interrupt = r_out_irq;

    `USART_RB_ASSERT_NEXT(a_advance_fills_result, advance, r_out_valid)
    `USART_RB_ASSERT_NEXT(a_request_held_on_stall, r_in_valid && !advance, r_in_valid)
    `USART_RB_ASSERT_NOW(a_irq_needs_enable, r_out_valid && r_out_irq, r_ctrl[CR_UE])
    `USART_RB_ASSERT_NOW(a_tc_implies_txe, r_tx_complete, r_tx_empty)

endmodule

`default_nettype wire

// ===== sim/usart_register_block_core_checker.sv =====
// Checker for the USART register block: tracks every request, predicts its result and compares.
module usart_register_block_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_reg_index,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_read_data,
    input  logic        i_tx_line,
    input  logic        i_interrupt,
    output int          o_results_due,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import usart_rb_pkg::*;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_line;
        logic        irq;
    } t_tick_result;

    // Shadow copy of the peripheral state.
    logic [15:0]       divisor;
    logic [CTRL_W-1:0] ctrl;
    logic [7:0]        rx_hold;
    logic              rx_full;
    logic [7:0]        tx_hold;
    logic              tx_empty;
    logic              tx_done;
    logic [9:0]        frame_shift;
    logic [3:0]        frame_bits;
    logic [15:0]       bit_count;

    t_tick_result awaited_results[$];
    int           mismatches = 0;

    assign o_errors = mismatches;

    task automatic report(input string what);
        if (mismatches < 50)
            $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_usart_state();
        divisor     = DIVISOR_RESET;
        ctrl        = '0;
        rx_hold     = '0;
        rx_full     = 1'b0;
        tx_hold     = '0;
        tx_empty    = 1'b1;
        tx_done     = 1'b1;
        frame_shift = '1;
        frame_bits  = '0;
        bit_count   = '0;
    endtask

    // One peripheral clock: the bus or receive action first, then the transmitter.
    task automatic step_usart_tick(input t_cmd cmd, input logic [2:0] idx,
                                   input logic [15:0] wd, input logic [7:0] rb,
                                   output t_tick_result res);
        logic [15:0] rd;
        logic [15:0] bit_period;
        rd = '0;
        case (cmd)
            CMD_READ: begin
                case (idx)
                    REG_STATUS: begin
                        rd[SR_RXNE] = rx_full;
                        rd[SR_TC]   = tx_done;
                        rd[SR_TXE]  = tx_empty;
                    end
                    REG_DATA: begin
                        rd[7:0] = rx_hold;
                        rx_full = 1'b0;
                    end
                    REG_DIVISOR: rd = divisor;
                    REG_CONTROL: rd[CTRL_W-1:0] = ctrl;
                    default: rd = '0;
                endcase
            end
            CMD_WRITE: begin
                if (idx == REG_DATA) begin
                    tx_hold  = wd[7:0];
                    tx_empty = 1'b0;
                    tx_done  = 1'b0;
                end else if (idx == REG_CONTROL) begin
                    ctrl = wd[CTRL_W-1:0];
                end
            end
            CMD_RX: begin
                if (ctrl[CR_UE] && ctrl[CR_RE]) begin
                    rx_hold = rb;
                    rx_full = 1'b1;
                end
            end
            default: ;
        endcase

        if (frame_bits != 0) begin
            bit_period = (divisor == 0) ? 16'd1 : divisor;
            bit_count  = bit_count + 16'd1;
            if (bit_count >= bit_period) begin
                bit_count   = '0;
                frame_shift = {1'b1, frame_shift[9:1]};
                frame_bits  = frame_bits - 4'd1;
                if (frame_bits == 0 && tx_empty)
                    tx_done = 1'b1;
            end
        end
        // A waiting byte only starts a frame once the previous one has finished.
        if (frame_bits == 0 && !tx_empty && ctrl[CR_UE] && ctrl[CR_TE]) begin
            frame_shift = {1'b1, tx_hold, 1'b0};
            frame_bits  = FRAME_BITS;
            bit_count   = '0;
            tx_empty    = 1'b1;
        end

        res.read_data = rd;
        res.tx_line   = frame_shift[0];
        res.irq       = ctrl[CR_UE] && ((ctrl[CR_TXEIE] && tx_empty) ||
                                        (ctrl[CR_RXNEIE] && rx_full));
    endtask

    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (!i_rst_n) begin
            clear_usart_state();
            awaited_results.delete();
            o_results_due <= 0;
        end else begin
            if (i_cfg_wr_en)
                divisor = i_cfg_wr_data;
            if (i_res_valid && i_res_ready) begin
                got = {i_read_data, i_tx_line, i_interrupt};
                if (awaited_results.size() == 0) begin
                    report($sformatf("result with no request outstanding: rd %h tx %b irq %b",
                                     got.read_data, got.tx_line, got.irq));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_data !== want.read_data || got.tx_line !== want.tx_line ||
                        got.irq !== want.irq)
                        report($sformatf("mismatch: rd %h/%h tx %b/%b irq %b/%b (got/exp)",
                                         got.read_data, want.read_data, got.tx_line,
                                         want.tx_line, got.irq, want.irq));
                end
            end
            if (i_req_valid && i_req_ready) begin
                step_usart_tick(t_cmd'(i_cmd), i_reg_index, i_write_data, i_rx_byte, want);
                awaited_results.push_back(want);
            end
            o_results_due <= awaited_results.size();
        end
    end

endmodule

// ===== sim/tb_usart_register_block_core.sv =====
// Testbench top for the USART register block: clock, reset, request and result traffic, verdict.
module tb_usart_register_block_core;
    timeunit 1ns;
    timeprecision 1ps;

    import usart_rb_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int BURST_LEN    = 60;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [2:0]  REG_UNUSED_LO = 3'd4;
    localparam logic [2:0]  REG_UNUSED_HI = 3'd6;
    localparam logic [15:0] CTRL_RUN      = (16'd1 << CR_UE) | (16'd1 << CR_TE) |
                                            (16'd1 << CR_RE);
    localparam logic [15:0] CTRL_TX_ONLY  = (16'd1 << CR_UE) | (16'd1 << CR_TE);
    localparam logic [15:0] CTRL_RE_ONLY  = 16'd1 << CR_RE;
    localparam logic [15:0] CTRL_FULL     = CTRL_RUN | (16'd1 << CR_TXEIE) |
                                            (16'd1 << CR_RXNEIE);

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  reg_index;
        logic [15:0] write_data;
        logic [7:0]  rx_byte;
    } t_tick_request;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic [1:0]  i_cmd         = CMD_TICK;
    logic [2:0]  i_reg_index   = '0;
    logic [15:0] i_write_data  = '0;
    logic [7:0]  i_rx_byte     = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_read_data;
    logic        o_tx_line;
    logic        o_interrupt;

    int results_due;
    int errors;
    bit hold_results = 1'b0;

    always #10 i_clk = ~i_clk;

    usart_register_block_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_reg_index   (i_reg_index),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_tx_line     (o_tx_line),
        .o_interrupt   (o_interrupt)
    );

    usart_register_block_core_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_cmd         (i_cmd),
        .i_reg_index   (i_reg_index),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_read_data   (o_read_data),
        .i_tx_line     (o_tx_line),
        .i_interrupt   (o_interrupt),
        .o_results_due (results_due),
        .o_errors      (errors)
    );

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly well-formed traffic: data writes, enabling control writes, reads, received bytes and ticks.
    function automatic t_tick_request random_request();
        t_tick_request req;
        int unsigned   r;
        req.cmd        = CMD_TICK;
        req.reg_index  = 3'($urandom_range(0, 6));
        req.write_data = 16'($urandom);
        req.rx_byte    = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) begin
            req.cmd = CMD_TICK;
        end else if (r < 65) begin
            req.cmd = CMD_READ;
            if ($urandom_range(0, 3) != 0)
                req.reg_index = $urandom_range(0, 1) ? REG_DATA : REG_STATUS;
        end else if (r < 85) begin
            req.cmd = CMD_WRITE;
            r = $urandom_range(0, 9);
            if (r < 6) begin
                req.reg_index = REG_DATA;
            end else if (r < 9) begin
                req.reg_index = REG_CONTROL;
                if ($urandom_range(0, 4) != 0)
                    req.write_data = req.write_data | CTRL_RUN;
            end
        end else begin
            req.cmd = CMD_RX;
        end
        return req;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input t_cmd cmd, input logic [2:0] idx,
                                input logic [15:0] wd, input logic [7:0] rb, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_reg_index  <= idx;
        i_write_data <= wd;
        i_rx_byte    <= rb;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_directed(input t_cmd cmd, input logic [2:0] idx,
                                 input logic [15:0] wd, input logic [7:0] rb);
        send_request(cmd, idx, wd, rb, pick_gap());
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] div, input int count, input bit squeeze);
        t_tick_request req;
        int            gap;
        write_divisor(div);
        for (int i = 0; i < count; i++) begin
            req = random_request();
            gap = pick_gap();
            // Keep offering requests while the result side is held off, so the block fills.
            if (squeeze && i == count / 2)
                hold_results = 1'b1;
            if (squeeze && i >= count / 2 && i < count / 2 + BURST_LEN)
                gap = 0;
            send_request(req.cmd, req.reg_index, req.write_data, req.rx_byte, gap);
        end
        wait_quiet();
    endtask

    initial begin : result_side
        int unsigned r;
        int          run;
        logic        level;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    level = 1'b1;
                    run   = $urandom_range(1, 40);
                end else if (r < 95) begin
                    level = 1'b0;
                    run   = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    run   = $urandom_range(10, 40);
                end
                i_ready <= level;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin : request_side
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_divisor(DIVISOR_RESET);

        // Reset values of every register, including unused addresses 4 and 6.
        send_directed(CMD_READ, REG_STATUS, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_DATA, 16'hFFFF, 8'hFF);
        send_directed(CMD_READ, REG_DIVISOR, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_CONTROL, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_UNUSED_LO, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_UNUSED_HI, 16'h0000, 8'h00);
        // A byte arriving while the peripheral is disabled is lost.
        send_directed(CMD_RX, REG_STATUS, 16'h0000, 8'h5A);
        send_directed(CMD_WRITE, REG_CONTROL, 16'hFFFF, 8'h00);
        send_directed(CMD_READ, REG_CONTROL, 16'h0000, 8'h00);
        // Writes to read-only and unused addresses are ignored.
        send_directed(CMD_WRITE, REG_STATUS, 16'hFFFF, 8'h00);
        send_directed(CMD_WRITE, REG_DIVISOR, 16'h0000, 8'h00);
        send_directed(CMD_WRITE, REG_UNUSED_HI, 16'hFFFF, 8'h00);
        // Second byte overwrites the first; reading data clears RXNE.
        send_directed(CMD_RX, REG_DATA, 16'h0000, 8'hFF);
        send_directed(CMD_RX, REG_DATA, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_STATUS, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_DATA, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_STATUS, 16'h0000, 8'h00);
        // First byte starts a frame, the next two fight over the holding register.
        send_directed(CMD_WRITE, REG_DATA, 16'h00A5, 8'h00);
        send_directed(CMD_WRITE, REG_DATA, 16'hFF3C, 8'h00);
        send_directed(CMD_WRITE, REG_DATA, 16'h0000, 8'h00);
        send_directed(CMD_READ, REG_STATUS, 16'h0000, 8'h00);
        // The running frame finishes even with the peripheral disabled.
        send_directed(CMD_WRITE, REG_CONTROL, 16'h0000, 8'h00);
        send_directed(CMD_TICK, REG_UNUSED_HI, 16'hFFFF, 8'hFF);
        send_directed(CMD_WRITE, REG_CONTROL, CTRL_RE_ONLY, 8'h00);
        send_directed(CMD_RX, REG_DATA, 16'h0000, 8'h81);
        send_directed(CMD_WRITE, REG_CONTROL, CTRL_TX_ONLY, 8'h00);
        send_directed(CMD_WRITE, REG_CONTROL, CTRL_FULL, 8'h00);
        wait_quiet();

        run_phase(16'd16, 400, 1'b0);
        // A divisor of zero behaves as a divisor of one.
        run_phase(16'd0, 250, 1'b1);
        run_phase(16'd1, 250, 1'b0);
        run_phase(16'hFFFF, 150, 1'b0);
        run_phase(16'($urandom_range(17, 40)), 350, 1'b0);
        run_phase(16'd16, 325, 1'b0);

        if (errors == 0)
            $display("tb_usart_register_block_core: done, clean");
        else
            $display("tb_usart_register_block_core: done, errors");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("tb_usart_register_block_core: done, errors");
        $finish;
    end

endmodule
